/* design/debounced_event_counter_7seg_top_assert.svh */
// Assertion macros for the debounced event counter top level.
`ifndef DEBOUNCED_EVENT_COUNTER_7SEG_TOP_ASSERT_SVH
`define DEBOUNCED_EVENT_COUNTER_7SEG_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DEC7S_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DEC7S_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/dec7s_pkg.sv */
// Shared types, constants and the segment decode for the event counter.
package dec7s_pkg;

   localparam int NUM_DIGITS_DEF = 4;
   localparam int CFG_W          = 8;
   localparam int COUNT_W        = 14;
   localparam int SEL_W          = 4;
   localparam int SEG_W          = 7;
   localparam int BCD_W          = 4;
   localparam int QUEUE_DEPTH    = 2;
   localparam int COUNT_MASK     = (1 << COUNT_W) - 1;

   localparam logic [CFG_W-1:0] QUALIFY_RESET = 8'd10;
   localparam logic [CFG_W-1:0] DIGIT_RESET   = 8'd2;

   typedef enum logic [0:0] {
      CSR_QUALIFY_TICKS = 1'b0,
      CSR_DIGIT_TICKS   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic hit;
   } tick_word_type;

   typedef struct packed {
      logic          valid;
      tick_word_type word;
   } push_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } queue_status_type;

   // Binary value of an all-nines counter, kept to the count width.
   function automatic logic [COUNT_W-1:0] count_reset(input int digits);
      int v;
      v = 0;
      for (int i = 0; i < digits; i++) begin
         v = ((v * 10) + 9) & COUNT_MASK;
      end
      return COUNT_W'(v);
   endfunction

   function automatic logic [SEG_W-1:0] seg_pattern(input logic [BCD_W-1:0] digit);
      logic [SEG_W-1:0] pattern;
      case (digit)
         4'd0:    pattern = 7'b0111111;
         4'd1:    pattern = 7'b0001100;
         4'd2:    pattern = 7'b1101011;
         4'd3:    pattern = 7'b1101110;
         4'd4:    pattern = 7'b1011100;
         4'd5:    pattern = 7'b1110110;
         4'd6:    pattern = 7'b1110111;
         4'd7:    pattern = 7'b0101100;
         4'd8:    pattern = 7'b1111111;
         4'd9:    pattern = 7'b1111110;
         default: pattern = 7'b0000000;
      endcase
      return pattern;
   endfunction

endpackage

/* design/debounced_event_counter_7seg_top.sv */
// Debounced event counter with a multiplexed 7-segment display output.
// The req channel takes one word per millisecond tick holding the sampled,
// active-low input level. The rsp channel gives one word per tick: one-hot
// digit select, that digit's segment pattern, the counter in binary and a
// flag set on the tick a qualified low pulse bumped the counter.
// A low pulse counts once it has stayed low for qualify_ticks ticks; the
// display moves to the next digit every digit_ticks ticks, in the order
// hundreds, tens, units, thousands for four digits.
// The csr port writes qualify_ticks (index 0) and digit_ticks (index 1); the
// user writes them only while no tick word is in flight, unenforced here.
// Throughput is one word per cycle while rsp_ready keeps the queue from
// filling. A result word passes from the qualifier into the queue, and the
// counter then loads it from the queue into the output register.
// A two-entry queue sits between them; when rsp_ready is
// low the queue fills and req_ready drops after two further words.
// Reset clears the qualifier to idle with the last level high, sets the
// counter to all nines (the first counted pulse shows zero), the display to
// position zero and the registers to 10 and 2.
`include "debounced_event_counter_7seg_top_assert.svh"

module debounced_event_counter_7seg_top #(
   parameter int NUM_DIGITS = dec7s_pkg::NUM_DIGITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_pin_level,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [dec7s_pkg::SEL_W-1:0]      rsp_digit_select,
   output logic [dec7s_pkg::SEG_W-1:0]      rsp_segments,
   output logic [dec7s_pkg::COUNT_W-1:0]    rsp_count_value,
   output logic                             rsp_counted,
   input  logic                             csr_we,
   input  logic [0:0]                       csr_index,
   input  logic [dec7s_pkg::CFG_W-1:0]      csr_wdata
);

   logic [dec7s_pkg::CFG_W-1:0]  qualify_ticks_ff;
   logic [dec7s_pkg::CFG_W-1:0]  digit_ticks_ff;
   dec7s_pkg::push_type          push;
   dec7s_pkg::queue_status_type  q_status;
   dec7s_pkg::tick_word_type     head;
   logic                         pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         qualify_ticks_ff <= dec7s_pkg::QUALIFY_RESET;
         digit_ticks_ff   <= dec7s_pkg::DIGIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            dec7s_pkg::CSR_QUALIFY_TICKS: qualify_ticks_ff <= csr_wdata;
            dec7s_pkg::CSR_DIGIT_TICKS:   digit_ticks_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   dec7s_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pin_level (req_pin_level),
      .qualify_ticks (qualify_ticks_ff),
      .q_status      (q_status),
      .push          (push)
   );

   dec7s_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .q_status (q_status),
      .head     (head)
   );

   dec7s_back #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .head             (head),
      .pop              (pop),
      .digit_ticks      (digit_ticks_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digit_select (rsp_digit_select),
      .rsp_segments     (rsp_segments),
      .rsp_count_value  (rsp_count_value),
      .rsp_counted      (rsp_counted)
   );

   // an accepted word must be waiting in the queue on the next cycle
   `DEC7S_ASSERT_NEXT(a_accept_queued, clock, reset, req_valid && req_ready, q_status.nonempty, "accepted word missing from queue")

   // a new result only comes from a queued word
   `DEC7S_ASSERT_NOW(a_rsp_from_queue, clock, reset, $rose(rsp_valid), $past(q_status.nonempty), "result raised without a queued word")

   // at most one digit lit
   `DEC7S_ASSERT_NOW(a_select_onehot, clock, reset, rsp_valid, $onehot0(rsp_digit_select), "more than one digit selected")

endmodule

/* design/dec7s_front.sv */
// Front end: accepts tick words and qualifies low pulses into count hits.
module dec7s_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_pin_level,
   input  logic [dec7s_pkg::CFG_W-1:0]    qualify_ticks,
   input  dec7s_pkg::queue_status_type    q_status,
   output dec7s_pkg::push_type            push
);

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_QUAL = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   phase_type  phase_ff;
   phase_type  phase_in;
   phase_type  phase_mid;
   logic       last_level_ff;
   logic [7:0] low_ticks_ff;
   logic [7:0] low_ticks_in;
   logic       accept;
   logic       hit;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      phase_mid    = phase_ff;
      low_ticks_in = low_ticks_ff;
      if (!req_pin_level && last_level_ff) begin
         phase_mid    = PH_QUAL;
         low_ticks_in = 8'd1;
      end else if (!req_pin_level) begin
         unique case (phase_ff)
            PH_QUAL: begin
               // saturate the low-time count
               if (low_ticks_ff != 8'hFF) begin
                  low_ticks_in = low_ticks_ff + 8'd1;
               end
            end
            PH_DONE: phase_mid = PH_DONE;
            default: phase_mid = PH_IDLE;
         endcase
      end else begin
         phase_mid = PH_IDLE;
      end
      hit      = (phase_mid == PH_QUAL) && (low_ticks_in >= qualify_ticks);
      phase_in = hit ? PH_DONE : phase_mid;
   end

   assign push.valid    = accept;
   assign push.word.hit = hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         last_level_ff <= 1'b1;
         low_ticks_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         last_level_ff <= req_pin_level;
         low_ticks_ff  <= low_ticks_in;
      end
   end

endmodule

/* design/dec7s_queue.sv */
// Short word queue between the qualifier and the counter/display back end.
module dec7s_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  dec7s_pkg::push_type         push,
   input  logic                        pop,
   output dec7s_pkg::queue_status_type q_status,
   output dec7s_pkg::tick_word_type    head
);

   localparam int DEPTH = dec7s_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dec7s_pkg::tick_word_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] fill_ff;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   assign q_status.full     = (fill_ff == CNT_W'(DEPTH));
   assign q_status.nonempty = (fill_ff != '0);
   assign head              = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (push.valid && !pop) begin
            fill_ff <= fill_ff + CNT_W'(1);
         end else if (pop && !push.valid) begin
            fill_ff <= fill_ff - CNT_W'(1);
         end
      end
   end

endmodule

/* design/dec7s_back.sv */
// Back end: BCD counter, binary count, display mux and the result register.
module dec7s_back #(
   parameter int NUM_DIGITS = dec7s_pkg::NUM_DIGITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dec7s_pkg::queue_status_type      q_status,
   input  dec7s_pkg::tick_word_type         head,
   output logic                             pop,
   input  logic [dec7s_pkg::CFG_W-1:0]      digit_ticks,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [dec7s_pkg::SEL_W-1:0]      rsp_digit_select,
   output logic [dec7s_pkg::SEG_W-1:0]      rsp_segments,
   output logic [dec7s_pkg::COUNT_W-1:0]    rsp_count_value,
   output logic                             rsp_counted
);

   localparam int POS_W   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int BCD_W   = dec7s_pkg::BCD_W;
   localparam int COUNT_W = dec7s_pkg::COUNT_W;
   localparam int SEL_W   = dec7s_pkg::SEL_W;
   localparam int CFG_W   = dec7s_pkg::CFG_W;
   localparam logic [COUNT_W-1:0] COUNT_INIT = dec7s_pkg::count_reset(NUM_DIGITS);

   logic [BCD_W-1:0]   digits_ff  [NUM_DIGITS];
   logic [BCD_W-1:0]   digits_inc [NUM_DIGITS];
   logic [BCD_W-1:0]   digits_in  [NUM_DIGITS];
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   pos_in;
   logic [POS_W-1:0]   shown_idx;
   logic [CFG_W-1:0]   mux_ticks_ff;
   logic [CFG_W-1:0]   mux_ticks_in;
   logic [CFG_W:0]     ticks_sum;
   logic               advance;
   logic               carry;
   logic               bump;
   logic [SEL_W-1:0]   select_in;

   logic                             rsp_valid_ff;
   logic [SEL_W-1:0]                 rsp_digit_select_ff;
   logic [dec7s_pkg::SEG_W-1:0]      rsp_segments_ff;
   logic [COUNT_W-1:0]               rsp_count_value_ff;
   logic                             rsp_counted_ff;

   assign pop  = q_status.nonempty && (!rsp_valid_ff || rsp_ready);
   assign bump = pop && head.hit;

   // ripple the BCD carry from the units digit up
   always_comb begin
      carry = 1'b1;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         digits_inc[i] = digits_ff[i];
         if (carry) begin
            if (digits_ff[i] >= 4'd9) begin
               digits_inc[i] = '0;
            end else begin
               digits_inc[i] = digits_ff[i] + 4'd1;
               carry         = 1'b0;
            end
         end
      end
      for (int i = 0; i < NUM_DIGITS; i++) begin
         digits_in[i] = bump ? digits_inc[i] : digits_ff[i];
      end
      // all nines wrap to zero, otherwise the binary count tracks the BCD one
      if (!bump) begin
         count_in = count_ff;
      end else if (carry) begin
         count_in = '0;
      end else begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   // last position shows the top digit, the rest count down from the next one
   always_comb begin
      if (pos_ff == POS_W'(NUM_DIGITS - 1)) begin
         shown_idx = POS_W'(NUM_DIGITS - 1);
      end else begin
         shown_idx = POS_W'(NUM_DIGITS - 2) - pos_ff;
      end
      for (int i = 0; i < SEL_W; i++) begin
         select_in[i] = (i < NUM_DIGITS) && (pos_ff == POS_W'(i));
      end
   end

   always_comb begin
      ticks_sum    = {1'b0, mux_ticks_ff} + (CFG_W + 1)'(1);
      advance      = (ticks_sum >= {1'b0, digit_ticks});
      mux_ticks_in = advance ? '0 : ticks_sum[CFG_W-1:0];
      if (!advance) begin
         pos_in = pos_ff;
      end else if (pos_ff == POS_W'(NUM_DIGITS - 1)) begin
         pos_in = '0;
      end else begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digits_ff[i] <= 4'd9;
         end
         count_ff     <= COUNT_INIT;
         pos_ff       <= '0;
         mux_ticks_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         digits_ff    <= digits_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         mux_ticks_ff <= mux_ticks_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_digit_select_ff <= select_in;
         rsp_segments_ff     <= dec7s_pkg::seg_pattern(digits_in[shown_idx]);
         rsp_count_value_ff  <= count_in;
         rsp_counted_ff      <= head.hit;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digit_select = rsp_digit_select_ff;
   assign rsp_segments     = rsp_segments_ff;
   assign rsp_count_value  = rsp_count_value_ff;
   assign rsp_counted      = rsp_counted_ff;

endmodule

/* tb/debounced_event_counter_7seg_checker.sv */
// Checker for the event counter: predicts each display word and compares it.
module debounced_event_counter_7seg_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_pin_level,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [dec7s_pkg::SEL_W-1:0]   rsp_digit_select,
   input  logic [dec7s_pkg::SEG_W-1:0]   rsp_segments,
   input  logic [dec7s_pkg::COUNT_W-1:0] rsp_count_value,
   input  logic                          rsp_counted,
   input  logic                          csr_we,
   input  logic [0:0]                    csr_index,
   input  logic [dec7s_pkg::CFG_W-1:0]   csr_wdata,
   output int                            fail_count,
   output int                            pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      QUAL_IDLE,
      QUAL_LOW,
      QUAL_DONE
   } qual_phase_type;

   typedef struct packed {
      logic [dec7s_pkg::SEL_W-1:0]   sel;
      logic [dec7s_pkg::SEG_W-1:0]   seg;
      logic [dec7s_pkg::COUNT_W-1:0] count;
      logic                          counted;
   } display_word_type;

   localparam logic [dec7s_pkg::SEG_W-1:0] SEG_LUT [16] = '{
      7'b0111111, 7'b0001100, 7'b1101011, 7'b1101110, 7'b1011100,
      7'b1110110, 7'b1110111, 7'b0101100, 7'b1111111, 7'b1111110,
      7'b0, 7'b0, 7'b0, 7'b0, 7'b0, 7'b0
   };

   logic [dec7s_pkg::CFG_W-1:0] qualify_cfg;
   logic [dec7s_pkg::CFG_W-1:0] digit_cfg;
   logic                        last_level;
   qual_phase_type              phase;
   logic [7:0]                  low_ticks;
   logic [dec7s_pkg::BCD_W-1:0] bcd [dec7s_pkg::NUM_DIGITS_DEF];
   logic [1:0]                  mux_pos;
   logic [7:0]                  mux_ticks;
   display_word_type            expected_display[$];

   task automatic count_tick(input logic level);
      display_word_type w;
      logic             hit;
      logic             carry;
      logic [1:0]       idx;
      int               value;
      int               i;
      hit = 1'b0;
      if (level == 1'b0 && last_level == 1'b1) begin
         phase = QUAL_LOW;
         low_ticks = 8'd1;
      end else if (level == 1'b0 && phase == QUAL_LOW) begin
         if (low_ticks != 8'hFF) low_ticks = low_ticks + 8'd1;
      end else if (level == 1'b1) begin
         phase = QUAL_IDLE;
      end
      if (phase == QUAL_LOW && low_ticks >= qualify_cfg) begin
         carry = 1'b1;
         for (i = 0; i < dec7s_pkg::NUM_DIGITS_DEF; i++) begin
            if (carry) begin
               if (bcd[i] >= 4'd9) begin
                  bcd[i] = 4'd0;
               end else begin
                  bcd[i] = bcd[i] + 4'd1;
                  carry = 1'b0;
               end
            end
         end
         hit = 1'b1;
         phase = QUAL_DONE;
      end
      last_level = level;

      // Display order is hundreds, tens, units, then thousands.
      idx = (mux_pos == 2'd3) ? 2'd3 : 2'd2 - mux_pos;
      value = 0;
      for (i = dec7s_pkg::NUM_DIGITS_DEF - 1; i >= 0; i--) value = value * 10 + bcd[i];
      w.sel = 4'b0001 << mux_pos;
      w.seg = SEG_LUT[bcd[idx]];
      w.count = value[dec7s_pkg::COUNT_W-1:0];
      w.counted = hit;
      expected_display.push_back(w);

      mux_ticks = mux_ticks + 8'd1;
      if (mux_ticks >= digit_cfg) begin
         mux_ticks = 8'd0;
         mux_pos = mux_pos + 2'd1;
      end
   endtask

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, what, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      display_word_type w;
      if (reset) begin
         qualify_cfg = dec7s_pkg::QUALIFY_RESET;
         digit_cfg = dec7s_pkg::DIGIT_RESET;
         last_level = 1'b1;
         phase = QUAL_IDLE;
         low_ticks = 8'd0;
         for (int i = 0; i < dec7s_pkg::NUM_DIGITS_DEF; i++) bcd[i] = 4'd9;
         mux_pos = 2'd0;
         mux_ticks = 8'd0;
         expected_display.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (dec7s_pkg::csr_index_type'(csr_index))
               dec7s_pkg::CSR_QUALIFY_TICKS: qualify_cfg = csr_wdata;
               dec7s_pkg::CSR_DIGIT_TICKS:   digit_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) count_tick(req_pin_level);
         if (rsp_valid && rsp_ready) begin
            if (expected_display.size() == 0) begin
               $display("%0t: display word with none expected, actual sel %0h seg %0h count %0d",
                        $realtime, rsp_digit_select, rsp_segments, rsp_count_value);
               fail_count++;
            end else begin
               w = expected_display.pop_front();
               check_field("digit_select", w.sel, rsp_digit_select);
               check_field("segments", w.seg, rsp_segments);
               check_field("count_value", w.count, rsp_count_value);
               check_field("counted", w.counted, rsp_counted);
            end
         end
      end
      pending_words <= expected_display.size();
   end

endmodule

/* tb/debounced_event_counter_7seg_top_tb.sv */
// Testbench top for the event counter: clock, reset, tick stimulus and verdict.
module debounced_event_counter_7seg_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_pin_level = 1'b1;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b1;
   logic [dec7s_pkg::SEL_W-1:0]   rsp_digit_select;
   logic [dec7s_pkg::SEG_W-1:0]   rsp_segments;
   logic [dec7s_pkg::COUNT_W-1:0] rsp_count_value;
   logic                          rsp_counted;
   logic                          csr_we = 1'b0;
   logic [0:0]                    csr_index = dec7s_pkg::CSR_QUALIFY_TICKS;
   logic [dec7s_pkg::CFG_W-1:0]   csr_wdata = '0;

   int fail_count;
   int pending_words;
   int cycles = 0;
   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;
   logic calm = 1'b0;

   logic [dec7s_pkg::CFG_W-1:0] phase_qual [6]  = '{8'd1, 8'd255, 8'd3, 8'd0, 8'd10, 8'd1};
   logic [dec7s_pkg::CFG_W-1:0] phase_digit [6] = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd7, 8'd3};
   int phase_items [6] = '{150, 400, 150, 150, 125, 125};

   debounced_event_counter_7seg_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pin_level    (req_pin_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digit_select (rsp_digit_select),
      .rsp_segments     (rsp_segments),
      .rsp_count_value  (rsp_count_value),
      .rsp_counted      (rsp_counted),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   debounced_event_counter_7seg_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pin_level    (req_pin_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digit_select (rsp_digit_select),
      .rsp_segments     (rsp_segments),
      .rsp_count_value  (rsp_count_value),
      .rsp_counted      (rsp_counted),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_words    (pending_words)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("debounced_event_counter_7seg_top_tb: FAIL");
         $finish;
      end
   end

   // Stall the result side in bursts.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 99) < stall_pct) stall_left <= $urandom_range(1, 6);
      end
   end

   // Present one tick word and hold it until accepted.
   task automatic send_tick(input logic level);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pin_level <= level;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [dec7s_pkg::CFG_W-1:0] qual,
                             input logic [dec7s_pkg::CFG_W-1:0] dig);
      csr_we <= 1'b1;
      csr_index <= dec7s_pkg::CSR_QUALIFY_TICKS;
      csr_wdata <= qual;
      @(posedge clock);
      csr_index <= dec7s_pkg::CSR_DIGIT_TICKS;
      csr_wdata <= dig;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly high runs followed by low runs around the qualify length, some noise.
   task automatic send_pulses(input int n_items, input int qual);
      int sent;
      int q;
      int high_len;
      int low_len;
      sent = 0;
      q = (qual == 0) ? 1 : qual;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            send_tick(1'($urandom_range(0, 1)));
            sent++;
         end else begin
            high_len = $urandom_range(1, 4);
            case ($urandom_range(0, 3))
               0:       low_len = (q > 1) ? q - 1 : 1;
               1:       low_len = q;
               2:       low_len = q + $urandom_range(1, 4);
               default: low_len = $urandom_range(1, q);
            endcase
            repeat (high_len) begin
               send_tick(1'b1);
               sent++;
            end
            repeat (low_len) begin
               send_tick(1'b0);
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: first counted pulse wraps all nines to zero, then
      // hold low past the count, then a short pulse that must be dropped.
      send_tick(1'b1);
      repeat (12) send_tick(1'b0);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
      send_tick(1'b1);
      drain();

      // Zero settings act as one: count on the edge tick, advance every tick.
      set_config(8'd0, 8'd0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      drain();

      for (int p = 0; p < 6; p++) begin
         set_config(phase_qual[p], phase_digit[p]);
         gap_pct <= (p % 3 == 0) ? 0 : $urandom_range(10, 40);
         stall_pct <= (p % 2 == 0) ? $urandom_range(10, 40) : 0;
         if (p == 5) calm <= 1'b1;
         send_pulses(phase_items[p], phase_qual[p]);
         drain();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_words == 0) begin
         $display("debounced_event_counter_7seg_top_tb: PASS");
      end else begin
         $display("debounced_event_counter_7seg_top_tb: FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/dec7s_pkg.sv
design/dec7s_front.sv
design/dec7s_queue.sv
design/dec7s_back.sv
design/debounced_event_counter_7seg_top.sv
tb/debounced_event_counter_7seg_checker.sv
tb/debounced_event_counter_7seg_top_tb.sv
